// ----- hdl/lmc_pkg.sv -----
`default_nettype none
package lmc_pkg;

    localparam int MAX_CELLS = 512;
    localparam int IDX_W     = $clog2(MAX_CELLS);
    localparam int CNT_W     = IDX_W + 1;
    localparam int FRAC_BITS = 28;
    localparam int ADDR_W    = 5;

    typedef logic signed [31:0] t_q;

    localparam t_q Q_MAX = 32'sh7fff_ffff;
    localparam t_q Q_MIN = 32'sh8000_0000;

    localparam logic [CNT_W-1:0] N_MIN = CNT_W'(2);
    localparam logic [CNT_W-1:0] N_MAX = CNT_W'(MAX_CELLS);

    localparam logic [2:0] FN_CLEAR = 3'd0;
    localparam logic [2:0] FN_CELL  = 3'd1;
    localparam logic [2:0] FN_LINK  = 3'd2;
    localparam logic [2:0] FN_STEP  = 3'd3;
    localparam logic [2:0] FN_READ  = 3'd4;

    localparam logic [2:0] REG_CELL_COUNT = 3'd0;
    localparam logic [2:0] REG_CELL_FREQ  = 3'd1;
    localparam logic [2:0] REG_LINK_FREQ  = 3'd2;
    localparam logic [2:0] REG_COUPLING   = 3'd3;
    localparam logic [2:0] REG_TIME_STEP  = 3'd4;

    localparam logic [CNT_W-1:0] CELL_COUNT_RST = CNT_W'(512);
    localparam t_q               CELL_FREQ_RST  = 32'sd268435456;
    localparam t_q               LINK_FREQ_RST  = 32'sd268435456;
    localparam t_q               COUPLING_RST   = 32'sd67108864;
    localparam logic [30:0]      TIME_STEP_RST  = 31'd536871;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_READ,
        ST_PASS1,
        ST_DRAIN1,
        ST_PASS2,
        ST_DRAIN2,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [CNT_W-1:0] cell_count;
        t_q               cell_freq;
        t_q               link_freq;
        t_q               coupling;
        logic [30:0]      time_step;
    } t_cfg;

    typedef struct packed {
        t_q amp_re;
        t_q amp_im;
        t_q bond_re;
        t_q bond_im;
        t_q det;
    } t_cell_word;

    typedef struct packed {
        t_q amp_re;
        t_q amp_im;
        t_q bond_re;
        t_q bond_im;
    } t_half_word;

    typedef struct packed {
        logic             pass2;
        logic             bond_en;
        logic [IDX_W-1:0] addr;
    } t_tag;

    typedef struct packed {
        logic       valid;
        t_tag       tag;
        t_q         cr;
        t_q         ci;
        t_q         bl_re;
        t_q         bl_im;
        t_q         bh_re;
        t_q         bh_im;
        t_q         br;
        t_q         bi;
        t_q         a0_re;
        t_q         a0_im;
        t_q         a1_re;
        t_q         a1_im;
        t_cell_word base;
    } t_dp_op;

    typedef struct packed {
        logic       valid;
        t_tag       tag;
        t_cell_word word;
    } t_dp_res;

    function automatic t_q sat_add(input t_q a, input t_q b);
        logic [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31]) begin
            return s[32] ? Q_MIN : Q_MAX;
        end
        return t_q'(s[31:0]);
    endfunction

    function automatic t_q sat_neg(input t_q a);
        if (a == Q_MIN) begin
            return Q_MAX;
        end
        return -a;
    endfunction

    function automatic t_q fix_scale(input logic signed [63:0] p);
        logic signed [63:0] q;
        q = p >>> FRAC_BITS;
        if (q > 64'sd2147483647) begin
            return Q_MAX;
        end
        if (q < -64'sd2147483648) begin
            return Q_MIN;
        end
        return t_q'(q[31:0]);
    endfunction

endpackage
`default_nettype wire

// ----- hdl/link_mediated_chain_rk2_step_top.sv -----
`default_nettype none
// channel   direction  handshake                  beat contents
// in        to block   i_in_valid / o_in_ready    func, position, value, detuning
// out       from block o_out_valid / i_out_ready  cell, right link, status
// cfg       to block   psel, penable, pwrite      five registers at 4*index
//
// read, write cell, write link: one access state, then done; out-of-range or unknown func: straight to done
// step: first pass, drain, second pass, drain; one entry a cycle through the state memory port in each pass
// clear: one memory entry a cycle over all 512 entries
// reset runs the same clearing pass over all 512 entries with in ready held low
// a new beat is taken while the previous result waits in the output register
module link_mediated_chain_rk2_step_top (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic [2:0]                 i_func,
    input  wire logic [8:0]                 i_position,
    input  wire logic signed [31:0]         i_value_re,
    input  wire logic signed [31:0]         i_value_im,
    input  wire logic signed [31:0]         i_detune_in,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic signed [31:0]              o_cell_re_out,
    output logic signed [31:0]              o_cell_im_out,
    output logic signed [31:0]              o_link_re_out,
    output logic signed [31:0]              o_link_im_out,
    output logic                            o_status,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [lmc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready
);

    localparam int IW = lmc_pkg::IDX_W;
    localparam int CW = lmc_pkg::CNT_W;

    lmc_pkg::t_cfg       w_cfg;
    lmc_pkg::t_state     r_state, n_state;
    logic [CW-1:0]       r_cnt, w_cnt_m1, w_n, w_n_m1;
    logic                r_boot;
    logic [2:0]          r_func;
    logic [IW-1:0]       r_pos;
    lmc_pkg::t_q         r_vre, r_vim, r_det;
    lmc_pkg::t_q         r_res_cre, r_res_cim, r_res_lre, r_res_lim;
    logic                r_res_st;
    logic                r_rd_v, r_rd_p2;
    logic [CW-1:0]       r_rd_idx, w_j_m1;
    lmc_pkg::t_cell_word r_prev_cell;
    lmc_pkg::t_half_word r_prev_half;
    logic                r_out_valid, r_out_st;
    lmc_pkg::t_q         r_out_cre, r_out_cim, r_out_lre, r_out_lim;

    logic                w_acc, w_oor, w_busy, w_dp_busy, w_issue, w_issue_p2, w_out_load;
    logic                w_st_we, w_hf_we;
    logic [IW-1:0]       w_st_raddr, w_st_waddr, w_hf_raddr, w_hf_waddr;
    lmc_pkg::t_cell_word w_st_wdata, w_st_rd, w_merge;
    lmc_pkg::t_half_word w_hf_wdata, w_hf_rd;
    lmc_pkg::t_dp_op     w_op;
    lmc_pkg::t_dp_res    w_res;

    lmc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    lmc_ram #(
        .WIDTH ($bits(lmc_pkg::t_cell_word)),
        .DEPTH (lmc_pkg::MAX_CELLS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (w_st_we),
        .i_waddr (w_st_waddr),
        .i_wdata (w_st_wdata),
        .i_raddr (w_st_raddr),
        .o_rdata (w_st_rd)
    );

    lmc_ram #(
        .WIDTH ($bits(lmc_pkg::t_half_word)),
        .DEPTH (lmc_pkg::MAX_CELLS)
    ) u_half_ram (
        .i_clk   (i_clk),
        .i_we    (w_hf_we),
        .i_waddr (w_hf_waddr),
        .i_wdata (w_hf_wdata),
        .i_raddr (w_hf_raddr),
        .o_rdata (w_hf_rd)
    );

    lmc_step_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_op    (w_op),
        .o_res   (w_res),
        .o_busy  (w_dp_busy)
    );

    always_comb begin
        if (w_cfg.cell_count < lmc_pkg::N_MIN) begin
            w_n = lmc_pkg::N_MIN;
        end else if (w_cfg.cell_count > lmc_pkg::N_MAX) begin
            w_n = lmc_pkg::N_MAX;
        end else begin
            w_n = w_cfg.cell_count;
        end
    end

    assign w_n_m1     = w_n - 1'b1;
    assign w_cnt_m1   = r_cnt - 1'b1;
    assign w_j_m1     = r_rd_idx - 1'b1;
    assign o_in_ready = (r_state == lmc_pkg::ST_IDLE);
    assign w_acc      = i_in_valid && o_in_ready;
    assign w_busy     = r_rd_v || w_dp_busy;
    assign w_out_load = (r_state == lmc_pkg::ST_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        unique case (i_func)
            lmc_pkg::FN_CELL, lmc_pkg::FN_READ: w_oor = ({1'b0, i_position} >= w_n);
            lmc_pkg::FN_LINK:                   w_oor = ({1'b0, i_position} >= w_n_m1);
            default:                            w_oor = 1'b0;
        endcase
    end

    always_comb begin
        w_merge = w_st_rd;
        if (r_func == lmc_pkg::FN_CELL) begin
            w_merge.amp_re = r_vre;
            w_merge.amp_im = r_vim;
            w_merge.det    = r_det;
        end else begin
            w_merge.bond_re = r_vre;
            w_merge.bond_im = r_vim;
        end
    end

    // operands: first pass lags links by one entry, second pass lags cells by one
    always_comb begin
        w_op.valid       = r_rd_v;
        w_op.tag.pass2   = r_rd_p2;
        if (!r_rd_p2) begin
            w_op.tag.bond_en = (r_rd_idx != '0);
            w_op.tag.addr    = r_rd_idx[IW-1:0];
            w_op.cr          = w_st_rd.amp_re;
            w_op.ci          = w_st_rd.amp_im;
            w_op.bl_re       = (r_rd_idx != '0) ? r_prev_cell.bond_re : '0;
            w_op.bl_im       = (r_rd_idx != '0) ? r_prev_cell.bond_im : '0;
            w_op.bh_re       = (r_rd_idx < w_n_m1) ? w_st_rd.bond_re : '0;
            w_op.bh_im       = (r_rd_idx < w_n_m1) ? w_st_rd.bond_im : '0;
            w_op.br          = r_prev_cell.bond_re;
            w_op.bi          = r_prev_cell.bond_im;
            w_op.a0_re       = r_prev_cell.amp_re;
            w_op.a0_im       = r_prev_cell.amp_im;
            w_op.a1_re       = w_st_rd.amp_re;
            w_op.a1_im       = w_st_rd.amp_im;
            w_op.base.amp_re  = w_st_rd.amp_re;
            w_op.base.amp_im  = w_st_rd.amp_im;
            w_op.base.bond_re = r_prev_cell.bond_re;
            w_op.base.bond_im = r_prev_cell.bond_im;
            w_op.base.det     = w_st_rd.det;
        end else begin
            w_op.valid       = r_rd_v && (r_rd_idx != '0);
            w_op.tag.bond_en = (r_rd_idx < w_n);
            w_op.tag.addr    = w_j_m1[IW-1:0];
            w_op.cr          = r_prev_half.amp_re;
            w_op.ci          = r_prev_half.amp_im;
            w_op.bl_re       = (r_rd_idx > CW'(1)) ? r_prev_half.bond_re : '0;
            w_op.bl_im       = (r_rd_idx > CW'(1)) ? r_prev_half.bond_im : '0;
            w_op.bh_re       = (r_rd_idx < w_n) ? w_hf_rd.bond_re : '0;
            w_op.bh_im       = (r_rd_idx < w_n) ? w_hf_rd.bond_im : '0;
            w_op.br          = w_hf_rd.bond_re;
            w_op.bi          = w_hf_rd.bond_im;
            w_op.a0_re       = r_prev_half.amp_re;
            w_op.a0_im       = r_prev_half.amp_im;
            w_op.a1_re       = w_hf_rd.amp_re;
            w_op.a1_im       = w_hf_rd.amp_im;
            w_op.base        = w_st_rd;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lmc_pkg::ST_CLEAR: begin
                if (r_cnt == CW'(lmc_pkg::MAX_CELLS - 1)) begin
                    n_state = r_boot ? lmc_pkg::ST_IDLE : lmc_pkg::ST_DONE;
                end
            end
            lmc_pkg::ST_IDLE: begin
                if (w_acc) begin
                    unique case (i_func)
                        lmc_pkg::FN_CLEAR: n_state = lmc_pkg::ST_CLEAR;
                        lmc_pkg::FN_CELL,
                        lmc_pkg::FN_LINK:  n_state = w_oor ? lmc_pkg::ST_DONE : lmc_pkg::ST_WRITE;
                        lmc_pkg::FN_STEP:  n_state = lmc_pkg::ST_PASS1;
                        lmc_pkg::FN_READ:  n_state = w_oor ? lmc_pkg::ST_DONE : lmc_pkg::ST_READ;
                        default:           n_state = lmc_pkg::ST_DONE;
                    endcase
                end
            end
            lmc_pkg::ST_WRITE, lmc_pkg::ST_READ: n_state = lmc_pkg::ST_DONE;
            lmc_pkg::ST_PASS1: begin
                if (r_cnt == w_n_m1) begin
                    n_state = lmc_pkg::ST_DRAIN1;
                end
            end
            lmc_pkg::ST_DRAIN1: begin
                if (!w_busy) begin
                    n_state = lmc_pkg::ST_PASS2;
                end
            end
            lmc_pkg::ST_PASS2: begin
                if (r_cnt == w_n) begin
                    n_state = lmc_pkg::ST_DRAIN2;
                end
            end
            lmc_pkg::ST_DRAIN2: begin
                if (!w_busy) begin
                    n_state = lmc_pkg::ST_DONE;
                end
            end
            lmc_pkg::ST_DONE: begin
                if (w_out_load) begin
                    n_state = lmc_pkg::ST_IDLE;
                end
            end
            default: n_state = lmc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        w_st_raddr = i_position;
        w_st_we    = 1'b0;
        w_st_waddr = r_pos;
        w_st_wdata = w_merge;
        w_hf_raddr = r_cnt[IW-1:0];
        w_issue    = 1'b0;
        w_issue_p2 = 1'b0;
        unique case (r_state)
            lmc_pkg::ST_CLEAR: begin
                w_st_we    = 1'b1;
                w_st_waddr = r_cnt[IW-1:0];
                w_st_wdata = '0;
            end
            lmc_pkg::ST_WRITE: begin
                w_st_we = 1'b1;
            end
            lmc_pkg::ST_PASS1: begin
                w_st_raddr = r_cnt[IW-1:0];
                w_issue    = 1'b1;
            end
            lmc_pkg::ST_PASS2: begin
                w_st_raddr = (r_cnt == '0) ? '0 : w_cnt_m1[IW-1:0];
                w_issue    = 1'b1;
                w_issue_p2 = 1'b1;
            end
            default: begin
            end
        endcase
        if (w_res.valid && w_res.tag.pass2) begin
            w_st_we    = 1'b1;
            w_st_waddr = w_res.tag.addr;
            w_st_wdata = w_res.word;
        end
    end

    assign w_hf_we            = w_res.valid && !w_res.tag.pass2;
    assign w_hf_waddr         = w_res.tag.addr;
    assign w_hf_wdata.amp_re  = w_res.word.amp_re;
    assign w_hf_wdata.amp_im  = w_res.word.amp_im;
    assign w_hf_wdata.bond_re = w_res.word.bond_re;
    assign w_hf_wdata.bond_im = w_res.word.bond_im;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lmc_pkg::ST_CLEAR;
            r_cnt       <= '0;
            r_boot      <= 1'b1;
            r_rd_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rd_v  <= w_issue;
            priority if (w_acc || r_state == lmc_pkg::ST_DRAIN1) begin
                r_cnt <= '0;
            end else if (r_state == lmc_pkg::ST_CLEAR || r_state == lmc_pkg::ST_PASS1
                         || r_state == lmc_pkg::ST_PASS2) begin
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_cnt <= r_cnt;
            end
            if (r_state == lmc_pkg::ST_CLEAR && n_state != lmc_pkg::ST_CLEAR) begin
                r_boot <= 1'b0;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_p2  <= w_issue_p2;
        r_rd_idx <= r_cnt;
        if (r_rd_v) begin
            if (r_rd_p2) begin
                r_prev_half <= w_hf_rd;
            end else begin
                r_prev_cell <= w_st_rd;
            end
        end
        if (w_acc) begin
            r_func    <= i_func;
            r_pos     <= i_position;
            r_vre     <= i_value_re;
            r_vim     <= i_value_im;
            r_det     <= i_detune_in;
            r_res_cre <= '0;
            r_res_cim <= '0;
            r_res_lre <= '0;
            r_res_lim <= '0;
            r_res_st  <= w_oor;
        end
        if (r_state == lmc_pkg::ST_READ) begin
            r_res_cre <= w_st_rd.amp_re;
            r_res_cim <= w_st_rd.amp_im;
            if ({1'b0, r_pos} < w_n_m1) begin
                r_res_lre <= w_st_rd.bond_re;
                r_res_lim <= w_st_rd.bond_im;
            end
        end
        if (w_out_load) begin
            r_out_cre <= r_res_cre;
            r_out_cim <= r_res_cim;
            r_out_lre <= r_res_lre;
            r_out_lim <= r_res_lim;
            r_out_st  <= r_res_st;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_cell_re_out = r_out_cre;
    assign o_cell_im_out = r_out_cim;
    assign o_link_re_out = r_out_lre;
    assign o_link_im_out = r_out_lim;
    assign o_status      = r_out_st;

    a_half_wr_in_pass1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_hf_we |-> (r_state == lmc_pkg::ST_PASS1 || r_state == lmc_pkg::ST_DRAIN1))
        else $error("midpoint store written outside the first pass");

    a_state_wr_in_pass2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res.valid && w_res.tag.pass2)
        |-> (r_state == lmc_pkg::ST_PASS2 || r_state == lmc_pkg::ST_DRAIN2))
        else $error("state update outside the second pass");

    a_pass2_empty_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == lmc_pkg::ST_PASS2) |-> !w_dp_busy)
        else $error("second pass started with first pass in flight");

    a_pass2_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lmc_pkg::ST_PASS2) |-> (r_cnt <= w_n))
        else $error("second pass ran beyond the chain");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == lmc_pkg::ST_DONE))
        else $error("result raised without a finished item");

endmodule
`default_nettype wire

// ----- hdl/lmc_ram.sv -----
`default_nettype none
module lmc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ----- hdl/lmc_cfg.sv -----
`default_nettype none
module lmc_cfg (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [lmc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]               pwdata,
    output logic      [31:0]               prdata,
    output logic                           pready,
    output lmc_pkg::t_cfg                  o_cfg
);

    lmc_pkg::t_cfg r_cfg;
    logic          w_wr;

    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cell_count <= lmc_pkg::CELL_COUNT_RST;
            r_cfg.cell_freq  <= lmc_pkg::CELL_FREQ_RST;
            r_cfg.link_freq  <= lmc_pkg::LINK_FREQ_RST;
            r_cfg.coupling   <= lmc_pkg::COUPLING_RST;
            r_cfg.time_step  <= lmc_pkg::TIME_STEP_RST;
        end else if (w_wr) begin
            unique case (paddr[4:2])
                lmc_pkg::REG_CELL_COUNT: r_cfg.cell_count <= pwdata[lmc_pkg::CNT_W-1:0];
                lmc_pkg::REG_CELL_FREQ:  r_cfg.cell_freq  <= lmc_pkg::t_q'(pwdata);
                lmc_pkg::REG_LINK_FREQ:  r_cfg.link_freq  <= lmc_pkg::t_q'(pwdata);
                lmc_pkg::REG_COUPLING:   r_cfg.coupling   <= lmc_pkg::t_q'(pwdata);
                lmc_pkg::REG_TIME_STEP:  r_cfg.time_step  <= pwdata[30:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            lmc_pkg::REG_CELL_COUNT: prdata = 32'(r_cfg.cell_count);
            lmc_pkg::REG_CELL_FREQ:  prdata = r_cfg.cell_freq;
            lmc_pkg::REG_LINK_FREQ:  prdata = r_cfg.link_freq;
            lmc_pkg::REG_COUPLING:   prdata = r_cfg.coupling;
            lmc_pkg::REG_TIME_STEP:  prdata = {1'b0, r_cfg.time_step};
            default:                 prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

// ----- hdl/lmc_step_dp.sv -----
`default_nettype none
module lmc_step_dp (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire lmc_pkg::t_cfg   i_cfg,
    input  wire lmc_pkg::t_dp_op i_op,
    output lmc_pkg::t_dp_res     o_res,
    output logic                 o_busy
);

    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    lmc_pkg::t_tag r_tag1, r_tag2, r_tag3, r_tag4, r_tag5;
    lmc_pkg::t_cell_word r_base1, r_base2, r_base3, r_base4, r_word5;

    lmc_pkg::t_q r_w1, r_bsr1, r_bsi1, r_asr1, r_asi1, r_cr1, r_ci1, r_br1, r_bi1;
    logic signed [63:0] r_pwr2, r_pwi2, r_pgr2, r_pgi2, r_plr2, r_pli2, r_par2, r_pai2;
    lmc_pkg::t_q r_rcr3, r_rci3, r_rbr3, r_rbi3;
    logic signed [63:0] r_pcr4, r_pci4, r_pbr4, r_pbi4;
    lmc_pkg::t_q w_dt;

    // half step in the first pass, full step in the second
    assign w_dt = r_tag3.pass2 ? lmc_pkg::t_q'({1'b0, i_cfg.time_step})
                               : lmc_pkg::t_q'({2'b00, i_cfg.time_step[30:1]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v1 <= i_op.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        // operand sums
        r_tag1  <= i_op.tag;
        r_base1 <= i_op.base;
        r_w1    <= lmc_pkg::sat_add(i_cfg.cell_freq, i_op.base.det);
        r_bsr1  <= lmc_pkg::sat_add(i_op.bl_re, i_op.bh_re);
        r_bsi1  <= lmc_pkg::sat_add(i_op.bl_im, i_op.bh_im);
        r_asr1  <= lmc_pkg::sat_add(i_op.a0_re, i_op.a1_re);
        r_asi1  <= lmc_pkg::sat_add(i_op.a0_im, i_op.a1_im);
        r_cr1   <= i_op.cr;
        r_ci1   <= i_op.ci;
        r_br1   <= i_op.br;
        r_bi1   <= i_op.bi;
        // products for the rates
        r_tag2  <= r_tag1;
        r_base2 <= r_base1;
        r_pwr2  <= r_w1 * r_cr1;
        r_pwi2  <= r_w1 * r_ci1;
        r_pgr2  <= i_cfg.coupling * r_bsr1;
        r_pgi2  <= i_cfg.coupling * r_bsi1;
        r_plr2  <= i_cfg.link_freq * r_br1;
        r_pli2  <= i_cfg.link_freq * r_bi1;
        r_par2  <= i_cfg.coupling * r_asr1;
        r_pai2  <= i_cfg.coupling * r_asi1;
        // rates, multiplied by -i
        r_tag3  <= r_tag2;
        r_base3 <= r_base2;
        r_rcr3  <= lmc_pkg::sat_add(lmc_pkg::fix_scale(r_pwi2), lmc_pkg::fix_scale(r_pgi2));
        r_rci3  <= lmc_pkg::sat_neg(
                   lmc_pkg::sat_add(lmc_pkg::fix_scale(r_pwr2), lmc_pkg::fix_scale(r_pgr2)));
        r_rbr3  <= lmc_pkg::sat_add(lmc_pkg::fix_scale(r_pli2), lmc_pkg::fix_scale(r_pai2));
        r_rbi3  <= lmc_pkg::sat_neg(
                   lmc_pkg::sat_add(lmc_pkg::fix_scale(r_plr2), lmc_pkg::fix_scale(r_par2)));
        // rate times step
        r_tag4  <= r_tag3;
        r_base4 <= r_base3;
        r_pcr4  <= w_dt * r_rcr3;
        r_pci4  <= w_dt * r_rci3;
        r_pbr4  <= w_dt * r_rbr3;
        r_pbi4  <= w_dt * r_rbi3;
        // update
        r_tag5          <= r_tag4;
        r_word5.det     <= r_base4.det;
        r_word5.amp_re  <= lmc_pkg::sat_add(r_base4.amp_re, lmc_pkg::fix_scale(r_pcr4));
        r_word5.amp_im  <= lmc_pkg::sat_add(r_base4.amp_im, lmc_pkg::fix_scale(r_pci4));
        r_word5.bond_re <= r_tag4.bond_en
                         ? lmc_pkg::sat_add(r_base4.bond_re, lmc_pkg::fix_scale(r_pbr4))
                         : r_base4.bond_re;
        r_word5.bond_im <= r_tag4.bond_en
                         ? lmc_pkg::sat_add(r_base4.bond_im, lmc_pkg::fix_scale(r_pbi4))
                         : r_base4.bond_im;
    end

    assign o_res.valid = r_v5;
    assign o_res.tag   = r_tag5;
    assign o_res.word  = r_word5;
    assign o_busy      = r_v1 || r_v2 || r_v3 || r_v4 || r_v5;

endmodule
`default_nettype wire

// ----- tb/chain_checker.sv -----
`timescale 1ns / 100ps
`default_nettype none
module chain_checker (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    input  wire logic                       i_in_ready,
    input  wire logic [2:0]                 i_func,
    input  wire logic [8:0]                 i_position,
    input  wire logic signed [31:0]         i_value_re,
    input  wire logic signed [31:0]         i_value_im,
    input  wire logic signed [31:0]         i_detune_in,
    input  wire logic                       i_out_valid,
    input  wire logic                       i_out_ready,
    input  wire logic signed [31:0]         i_cell_re_out,
    input  wire logic signed [31:0]         i_cell_im_out,
    input  wire logic signed [31:0]         i_link_re_out,
    input  wire logic signed [31:0]         i_link_im_out,
    input  wire logic                       i_status,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [lmc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    input  wire logic                       pready,
    output int                              o_fails,
    output int                              o_pending
);

    typedef struct {
        lmc_pkg::t_q cre;
        lmc_pkg::t_q cim;
        lmc_pkg::t_q lre;
        lmc_pkg::t_q lim;
        logic        st;
    } t_beat;

    t_beat beats_due[$];

    logic [9:0]  cnt_reg;
    lmc_pkg::t_q cell_freq;
    lmc_pkg::t_q link_freq;
    lmc_pkg::t_q gain;
    logic [30:0] dt;

    lmc_pkg::t_q amp_re [lmc_pkg::MAX_CELLS];
    lmc_pkg::t_q amp_im [lmc_pkg::MAX_CELLS];
    lmc_pkg::t_q bond_re[lmc_pkg::MAX_CELLS];
    lmc_pkg::t_q bond_im[lmc_pkg::MAX_CELLS];
    lmc_pkg::t_q detune [lmc_pkg::MAX_CELLS];
    lmc_pkg::t_q mid_amp_re [lmc_pkg::MAX_CELLS];
    lmc_pkg::t_q mid_amp_im [lmc_pkg::MAX_CELLS];
    lmc_pkg::t_q mid_bond_re[lmc_pkg::MAX_CELLS];
    lmc_pkg::t_q mid_bond_im[lmc_pkg::MAX_CELLS];
    lmc_pkg::t_q d_cre[lmc_pkg::MAX_CELLS];
    lmc_pkg::t_q d_cim[lmc_pkg::MAX_CELLS];
    lmc_pkg::t_q d_bre[lmc_pkg::MAX_CELLS];
    lmc_pkg::t_q d_bim[lmc_pkg::MAX_CELLS];

    int fails = 0;

    assign o_fails   = fails;
    assign o_pending = beats_due.size();

    function automatic lmc_pkg::t_q clip(input longint v);
        if (v > 64'sd2147483647) begin
            return lmc_pkg::Q_MAX;
        end
        if (v < -64'sd2147483648) begin
            return lmc_pkg::Q_MIN;
        end
        return lmc_pkg::t_q'(v);
    endfunction

    // floor of the scaled product
    function automatic lmc_pkg::t_q qmul(input longint a, input longint b);
        longint p;
        p = a * b;
        return clip(p >>> lmc_pkg::FRAC_BITS);
    endfunction

    function automatic int cells_in_use();
        if (cnt_reg < 2) begin
            return 2;
        end
        if (cnt_reg > lmc_pkg::MAX_CELLS) begin
            return lmc_pkg::MAX_CELLS;
        end
        return int'(cnt_reg);
    endfunction

    function automatic void clear_chain();
        for (int k = 0; k < lmc_pkg::MAX_CELLS; k++) begin
            amp_re[k] = '0; amp_im[k] = '0;
            bond_re[k] = '0; bond_im[k] = '0;
            detune[k] = '0;
        end
    endfunction

    // derivative of the chain at present (mid = 0) or midpoint state
    function automatic void chain_rates(input bit mid, input int n);
        longint sr, si;
        lmc_pkg::t_q w, hr, hi, cr, ci, cr1, ci1, br, bi;
        for (int k = 0; k < n; k++) begin
            sr = 0;
            si = 0;
            if (k < n - 1) begin
                sr += mid ? mid_bond_re[k] : bond_re[k];
                si += mid ? mid_bond_im[k] : bond_im[k];
            end
            if (k > 0) begin
                sr += mid ? mid_bond_re[k-1] : bond_re[k-1];
                si += mid ? mid_bond_im[k-1] : bond_im[k-1];
            end
            sr = clip(sr);
            si = clip(si);
            cr = mid ? mid_amp_re[k] : amp_re[k];
            ci = mid ? mid_amp_im[k] : amp_im[k];
            w  = clip(longint'(cell_freq) + detune[k]);
            hr = clip(longint'(qmul(w, cr)) + qmul(gain, sr));
            hi = clip(longint'(qmul(w, ci)) + qmul(gain, si));
            d_cre[k] = hi;
            d_cim[k] = clip(-longint'(hr));
        end
        for (int k = 0; k < n - 1; k++) begin
            cr  = mid ? mid_amp_re[k]   : amp_re[k];
            ci  = mid ? mid_amp_im[k]   : amp_im[k];
            cr1 = mid ? mid_amp_re[k+1] : amp_re[k+1];
            ci1 = mid ? mid_amp_im[k+1] : amp_im[k+1];
            br  = mid ? mid_bond_re[k]  : bond_re[k];
            bi  = mid ? mid_bond_im[k]  : bond_im[k];
            sr  = clip(longint'(cr) + cr1);
            si  = clip(longint'(ci) + ci1);
            hr  = clip(longint'(qmul(link_freq, br)) + qmul(gain, sr));
            hi  = clip(longint'(qmul(link_freq, bi)) + qmul(gain, si));
            d_bre[k] = hi;
            d_bim[k] = clip(-longint'(hr));
        end
    endfunction

    function automatic void midpoint_step();
        int     n;
        longint hdt, fdt;
        n   = cells_in_use();
        fdt = longint'(dt);
        hdt = fdt >>> 1;
        chain_rates(1'b0, n);
        for (int k = 0; k < n; k++) begin
            mid_amp_re[k] = clip(longint'(amp_re[k]) + qmul(hdt, d_cre[k]));
            mid_amp_im[k] = clip(longint'(amp_im[k]) + qmul(hdt, d_cim[k]));
        end
        for (int k = 0; k < n - 1; k++) begin
            mid_bond_re[k] = clip(longint'(bond_re[k]) + qmul(hdt, d_bre[k]));
            mid_bond_im[k] = clip(longint'(bond_im[k]) + qmul(hdt, d_bim[k]));
        end
        chain_rates(1'b1, n);
        for (int k = 0; k < n; k++) begin
            amp_re[k] = clip(longint'(amp_re[k]) + qmul(fdt, d_cre[k]));
            amp_im[k] = clip(longint'(amp_im[k]) + qmul(fdt, d_cim[k]));
        end
        for (int k = 0; k < n - 1; k++) begin
            bond_re[k] = clip(longint'(bond_re[k]) + qmul(fdt, d_bre[k]));
            bond_im[k] = clip(longint'(bond_im[k]) + qmul(fdt, d_bim[k]));
        end
    endfunction

    function automatic t_beat chain_outcome(input logic [2:0] fn, input int pos,
                                            input lmc_pkg::t_q vre, input lmc_pkg::t_q vim,
                                            input lmc_pkg::t_q det);
        t_beat b;
        int    n;
        n = cells_in_use();
        b = '{cre: '0, cim: '0, lre: '0, lim: '0, st: 1'b0};
        case (fn)
            lmc_pkg::FN_CLEAR: clear_chain();
            lmc_pkg::FN_CELL: begin
                if (pos < n) begin
                    amp_re[pos] = vre;
                    amp_im[pos] = vim;
                    detune[pos] = det;
                end else begin
                    b.st = 1'b1;
                end
            end
            lmc_pkg::FN_LINK: begin
                if (pos < n - 1) begin
                    bond_re[pos] = vre;
                    bond_im[pos] = vim;
                end else begin
                    b.st = 1'b1;
                end
            end
            lmc_pkg::FN_STEP: midpoint_step();
            lmc_pkg::FN_READ: begin
                if (pos < n) begin
                    b.cre = amp_re[pos];
                    b.cim = amp_im[pos];
                    if (pos < n - 1) begin
                        b.lre = bond_re[pos];
                        b.lim = bond_im[pos];
                    end
                end else begin
                    b.st = 1'b1;
                end
            end
            default: ;
        endcase
        return b;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
        fails++;
    endtask

    always @(posedge i_clk) begin
        t_beat want;
        if (!i_rst_n) begin
            cnt_reg   = lmc_pkg::CELL_COUNT_RST;
            cell_freq = lmc_pkg::CELL_FREQ_RST;
            link_freq = lmc_pkg::LINK_FREQ_RST;
            gain      = lmc_pkg::COUPLING_RST;
            dt        = lmc_pkg::TIME_STEP_RST;
            clear_chain();
            beats_due.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[lmc_pkg::ADDR_W-1:2])
                    lmc_pkg::REG_CELL_COUNT: cnt_reg   = pwdata[9:0];
                    lmc_pkg::REG_CELL_FREQ:  cell_freq = pwdata;
                    lmc_pkg::REG_LINK_FREQ:  link_freq = pwdata;
                    lmc_pkg::REG_COUPLING:   gain      = pwdata;
                    lmc_pkg::REG_TIME_STEP:  dt        = pwdata[30:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                beats_due.push_back(chain_outcome(i_func, int'(i_position), i_value_re,
                                                  i_value_im, i_detune_in));
            end
            if (i_out_valid && i_out_ready) begin
                if (beats_due.size() == 0) begin
                    report("result beat with none expected", 1, 0);
                end else begin
                    want = beats_due.pop_front();
                    if (i_cell_re_out !== want.cre) report("cell_re", i_cell_re_out, want.cre);
                    if (i_cell_im_out !== want.cim) report("cell_im", i_cell_im_out, want.cim);
                    if (i_link_re_out !== want.lre) report("link_re", i_link_re_out, want.lre);
                    if (i_link_im_out !== want.lim) report("link_im", i_link_im_out, want.lim);
                    if (i_status !== want.st) report("status", i_status, want.st);
                end
            end
        end
    end

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

    localparam int         LIMIT       = 1500000;
    localparam logic [2:0] REG_SPARE   = 3'd5;
    localparam logic [2:0] FN_BAD_LO   = 3'd5;
    localparam logic [2:0] FN_BAD_HI   = 3'd7;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [2:0]  func = '0;
    logic [8:0]  position = '0;
    lmc_pkg::t_q value_re = '0;
    lmc_pkg::t_q value_im = '0;
    lmc_pkg::t_q detune_in = '0;
    logic        out_ready = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [lmc_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;

    wire logic        in_ready;
    wire logic        out_valid;
    wire logic signed [31:0] cell_re, cell_im, link_re, link_im;
    wire logic        status;
    wire logic [31:0] prdata;
    wire logic        pready;
    int               fails;
    int               pending;

    int cyc = 0;
    int n_now = lmc_pkg::MAX_CELLS;

    always #6 clk = ~clk;

    link_mediated_chain_rk2_step_top u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_func(func), .i_position(position),
        .i_value_re(value_re), .i_value_im(value_im), .i_detune_in(detune_in),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_cell_re_out(cell_re), .o_cell_im_out(cell_im),
        .o_link_re_out(link_re), .o_link_im_out(link_im), .o_status(status),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    chain_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_func(func), .i_position(position),
        .i_value_re(value_re), .i_value_im(value_im), .i_detune_in(detune_in),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_cell_re_out(cell_re), .i_cell_im_out(cell_im),
        .i_link_re_out(link_re), .i_link_im_out(link_im), .i_status(status),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .o_fails(fails), .o_pending(pending)
    );

    // long stretch with no idling on either side
    function automatic bit quiet();
        return (cyc % 20000) < 5000;
    endfunction

    always @(posedge clk) begin
        cyc <= cyc + 1;
        out_ready <= quiet() ? 1'b1 : ($urandom_range(0, 99) >= 24);
        if (cyc > LIMIT) begin
            $display("[link_mediated_chain_rk2_step_top] ERROR");
            $finish;
        end
    end

    function automatic lmc_pkg::t_q pick_value();
        case ($urandom_range(0, 4))
            0, 1: return lmc_pkg::t_q'($urandom);
            2:    return lmc_pkg::t_q'(int'($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000);
            3:    return $urandom_range(0, 1) ? lmc_pkg::Q_MAX : lmc_pkg::Q_MIN;
            default: return lmc_pkg::t_q'(int'($urandom_range(0, 32'h0040_0000))
                                          - 32'sh0020_0000);
        endcase
    endfunction

    task automatic send(input logic [2:0] fn, input int pos, input lmc_pkg::t_q vre,
                        input lmc_pkg::t_q vim, input lmc_pkg::t_q det);
        if (!quiet() && $urandom_range(0, 99) < 24) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        func      <= fn;
        position  <= 9'(pos);
        value_re  <= vre;
        value_im  <= vim;
        detune_in <= det;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic configure(input int cnt, input lmc_pkg::t_q cf, input lmc_pkg::t_q lf,
                             input lmc_pkg::t_q cg, input logic [30:0] dt);
        settle();
        write_reg(lmc_pkg::REG_CELL_COUNT, 32'(cnt));
        write_reg(lmc_pkg::REG_CELL_FREQ, cf);
        write_reg(lmc_pkg::REG_LINK_FREQ, lf);
        write_reg(lmc_pkg::REG_COUPLING, cg);
        write_reg(lmc_pkg::REG_TIME_STEP, {1'b0, dt});
        n_now = (cnt < 2) ? 2 : (cnt > lmc_pkg::MAX_CELLS) ? lmc_pkg::MAX_CELLS : cnt;
    endtask

    task automatic random_item();
        int r, pos;
        r   = $urandom_range(0, 99);
        pos = $urandom_range(0, n_now - 1);
        if (r < 30) begin
            send(lmc_pkg::FN_CELL, pos, pick_value(), pick_value(), pick_value());
        end else if (r < 50) begin
            send(lmc_pkg::FN_LINK, (pos == n_now - 1) ? 0 : pos, pick_value(), pick_value(),
                 pick_value());
        end else if (r < 75) begin
            send(lmc_pkg::FN_READ, pos, pick_value(), pick_value(), pick_value());
        end else if (r < 87) begin
            send(lmc_pkg::FN_STEP, $urandom_range(0, 511), pick_value(), pick_value(),
                 pick_value());
        end else if (r < 91) begin
            send(lmc_pkg::FN_CLEAR, $urandom_range(0, 511), pick_value(), pick_value(),
                 pick_value());
        end else if (r < 96) begin
            send(3'($urandom_range(lmc_pkg::FN_CELL, lmc_pkg::FN_READ)),
                 $urandom_range(0, 511), pick_value(), pick_value(), pick_value());
        end else begin
            send(3'($urandom_range(FN_BAD_LO, FN_BAD_HI)), $urandom_range(0, 511),
                 pick_value(), pick_value(), pick_value());
        end
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        do @(posedge clk); while (!in_ready);

        // directed part on a four-cell chain
        configure(4, lmc_pkg::CELL_FREQ_RST, lmc_pkg::LINK_FREQ_RST, lmc_pkg::COUPLING_RST,
                  lmc_pkg::TIME_STEP_RST);
        write_reg(REG_SPARE, 32'hffff_ffff);
        send(lmc_pkg::FN_CELL, 0, lmc_pkg::Q_MAX, lmc_pkg::Q_MAX, lmc_pkg::Q_MAX);
        send(lmc_pkg::FN_CELL, 3, lmc_pkg::Q_MIN, lmc_pkg::Q_MIN, lmc_pkg::Q_MIN);
        send(lmc_pkg::FN_CELL, 1, 32'sh1000_0000, -32'sh0800_0000, 32'sh0100_0000);
        send(lmc_pkg::FN_LINK, 0, lmc_pkg::Q_MIN, lmc_pkg::Q_MAX, '0);
        send(lmc_pkg::FN_LINK, 2, 32'sh0400_0000, 32'sh0000_0001, '0);
        send(lmc_pkg::FN_LINK, 3, 32'sh0000_0001, 32'sh0000_0001, '0);
        send(lmc_pkg::FN_CELL, 4, 32'sh0000_0001, 32'sh0000_0001, '0);
        send(lmc_pkg::FN_READ, 0, '0, '0, '0);
        send(lmc_pkg::FN_READ, 3, '0, '0, '0);
        send(lmc_pkg::FN_READ, 4, '0, '0, '0);
        send(lmc_pkg::FN_READ, 511, '0, '0, '0);
        send(lmc_pkg::FN_STEP, 0, '0, '0, '0);
        for (int k = 0; k < 4; k++) send(lmc_pkg::FN_READ, k, '0, '0, '0);
        send(FN_BAD_LO, 1, lmc_pkg::Q_MAX, lmc_pkg::Q_MAX, lmc_pkg::Q_MAX);
        send(3'd6, 2, lmc_pkg::Q_MIN, lmc_pkg::Q_MIN, lmc_pkg::Q_MIN);
        send(FN_BAD_HI, 511, '1, '1, '1);
        send(lmc_pkg::FN_CLEAR, 0, '0, '0, '0);
        send(lmc_pkg::FN_READ, 0, '0, '0, '0);
        send(lmc_pkg::FN_LINK, 511, '0, '0, '0);
        send(lmc_pkg::FN_STEP, 0, '0, '0, '0);

        // random part over several register settings
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: configure(3, lmc_pkg::CELL_FREQ_RST, lmc_pkg::LINK_FREQ_RST,
                             lmc_pkg::COUPLING_RST, lmc_pkg::TIME_STEP_RST);
                1: configure(0, lmc_pkg::Q_MAX, lmc_pkg::Q_MIN, lmc_pkg::Q_MAX,
                             31'h7fff_ffff);
                2: configure(1, lmc_pkg::Q_MIN, lmc_pkg::Q_MAX, lmc_pkg::Q_MIN, 31'd0);
                3: configure(16, 32'sh0800_0000, -32'sh0400_0000, 32'sh0200_0000,
                             31'h0100_0000);
                4: configure(512, lmc_pkg::CELL_FREQ_RST, lmc_pkg::LINK_FREQ_RST,
                             lmc_pkg::COUPLING_RST, lmc_pkg::TIME_STEP_RST);
                5: configure(1023, pick_value(), pick_value(), pick_value(),
                             31'($urandom));
                6: configure(5, pick_value(), pick_value(), pick_value(),
                             31'($urandom_range(0, 32'h0400_0000)));
                default: configure(40, lmc_pkg::CELL_FREQ_RST, lmc_pkg::LINK_FREQ_RST,
                                   32'sh1000_0000, 31'h0080_0000);
            endcase
            repeat (65) random_item();
        end

        settle();
        repeat (50) @(posedge clk);
        if (fails == 0) begin
            $display("[link_mediated_chain_rk2_step_top] OK");
        end else begin
            $display("[link_mediated_chain_rk2_step_top] ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ----- link_mediated_chain_rk2_step_top.f -----
hdl/lmc_pkg.sv
hdl/lmc_ram.sv
hdl/lmc_cfg.sv
hdl/lmc_step_dp.sv
hdl/link_mediated_chain_rk2_step_top.sv
tb/chain_checker.sv
tb/tb_top.sv
